/* rtl/core/nst_pkg.sv */
// shared types and constants for the neighbor selector table
package nst_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam int ADDR_W = 32;
    localparam int SEQ_W  = 16;
    localparam int TIME_W = 32;
    localparam int MODE_W = 3;
    localparam int CNT_W  = 5;

    localparam logic [TIME_W-1:0] HOLD_TIME_RST = 32'd6000;

    localparam logic [MODE_W-1:0] MODE_HELLO  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ACK    = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] expiry;
    } t_entry;

endpackage

/* rtl/core/nst_entry_mem.sv */
// entry memory: one write port, one read port with registered read data
module nst_entry_mem #(
    parameter int DEPTH = nst_pkg::TABLE_ENTRIES,
    parameter int IDX_W = $clog2(nst_pkg::TABLE_ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  nst_pkg::t_entry      i_wdata,
    input  logic                 i_re,
    input  logic [IDX_W-1:0]     i_raddr,
    output nst_pkg::t_entry      o_rdata
);

    nst_pkg::t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/core/neighbor_selector_table_core.sv */
// top level of the neighbor selector table: scan sequencer, valid bits and result register
//
// usage
//   input channel: i_in_valid / o_in_stall with i_mode, i_node_addr, i_seq_num,
//   i_now_time. one item is taken at a time; o_in_stall is low only while idle.
//   output channel: o_out_valid / i_out_stall, one result item per input item.
//   config: i_cfg_we/i_cfg_wdata load hold_time; user writes only while idle, unenforced.
// timing
//   every item scans all TABLE_ENTRIES entries through the single read port of
//   the entry memory, one entry per cycle, then passes through the drain,
//   write-back and result hand-off states. a new item is taken only once the
//   block is back in idle after the hand-off.
// reset
//   synchronous, active low. all entries invalid, set sequence and changes flag
//   zero, hold_time 6000. the entry memory itself is not cleared.
// stall
//   a held result stays in the output register; the next item can be scanned
//   meanwhile and waits for the register before it is handed off.
module neighbor_selector_table_core #(
    parameter int TABLE_ENTRIES = nst_pkg::TABLE_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nst_pkg::TIME_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [nst_pkg::MODE_W-1:0]  i_mode,
    input  logic [nst_pkg::ADDR_W-1:0]  i_node_addr,
    input  logic [nst_pkg::SEQ_W-1:0]   i_seq_num,
    input  logic [nst_pkg::TIME_W-1:0]  i_now_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [nst_pkg::SEQ_W-1:0]   o_entry_seq,
    output logic                        o_inserted,
    output logic                        o_table_full,
    output logic [nst_pkg::CNT_W-1:0]   o_removed_count,
    output logic [nst_pkg::SEQ_W-1:0]   o_set_seq,
    output logic                        o_changes_pending
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [nst_pkg::TIME_W-1:0]       r_hold;
    logic [TABLE_ENTRIES-1:0]         r_valid;
    logic [nst_pkg::SEQ_W-1:0]        r_set_seq;
    logic                             r_chg;

    logic [nst_pkg::MODE_W-1:0]       r_mode;
    logic [nst_pkg::ADDR_W-1:0]       r_addr;
    logic [nst_pkg::SEQ_W-1:0]        r_seq;
    logic [nst_pkg::TIME_W-1:0]       r_now;

    logic [IDX_W-1:0]                 r_rd_idx;
    logic                             r_cmp_vld;
    logic [IDX_W-1:0]                 r_cmp_idx;

    logic                             r_hit;
    logic [IDX_W-1:0]                 r_hit_idx;
    logic [nst_pkg::SEQ_W-1:0]        r_hit_seq;
    logic                             r_free_ok;
    logic [IDX_W-1:0]                 r_free_idx;
    logic [nst_pkg::CNT_W-1:0]        r_cnt;

    logic                             r_res_found;
    logic [nst_pkg::SEQ_W-1:0]        r_res_eseq;
    logic                             r_res_ins;
    logic                             r_res_full;

    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_cmp_v;
    logic [nst_pkg::CNT_W-1:0]        w_cnt_inc;
    logic [nst_pkg::TIME_W:0]         w_sum;
    logic [nst_pkg::TIME_W-1:0]       w_expiry;
    logic                             w_is_hello;
    logic                             w_we;
    logic [IDX_W-1:0]                 w_waddr;
    nst_pkg::t_entry                  w_wdata;
    nst_pkg::t_entry                  w_rdata;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_cmp_v    = r_valid[r_cmp_idx];
    assign w_cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign w_is_hello = (r_mode == nst_pkg::MODE_HELLO);

    // saturating expiry
    assign w_sum    = {1'b0, r_now} + {1'b0, r_hold};
    assign w_expiry = w_sum[nst_pkg::TIME_W] ? '1 : w_sum[nst_pkg::TIME_W-1:0];

    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_free_idx;
        w_wdata.addr = r_addr;
        w_wdata.seq  = r_seq;
        w_wdata.expiry = w_expiry;
        if (r_state == ST_UPD && w_is_hello) begin
            if (r_hit) begin
                w_waddr = r_hit_idx;
                w_we    = (r_seq >= r_hit_seq);
            end else begin
                w_we    = r_free_ok;
            end
        end
    end

    nst_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_SCAN;
            ST_SCAN:  if (r_rd_idx == LAST_IDX) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_UPD;
            ST_UPD:   n_state = ST_FIN;
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hold    <= nst_pkg::HOLD_TIME_RST;
            r_valid   <= '0;
            r_set_seq <= '0;
            r_chg     <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end

            // one entry per cycle from the memory
            if (r_cmp_vld) begin
                case (r_mode)
                    nst_pkg::MODE_SWEEP: begin
                        if (w_cmp_v && (w_rdata.expiry < r_now)) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                            r_set_seq <= r_set_seq + 1'b1;
                            r_chg     <= 1'b1;
                        end
                    end
                    nst_pkg::MODE_CLEAR: begin
                        if (w_cmp_v) begin
                            r_valid[r_cmp_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            if (r_state == ST_UPD) begin
                if (w_is_hello && !r_hit && r_free_ok) begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_set_seq <= r_set_seq + 1'b1;
                    r_chg     <= 1'b1;
                end
                if (r_mode == nst_pkg::MODE_ACK) begin
                    r_chg <= 1'b0;
                end
            end
        end
    end

    // item capture, scan bookkeeping and result fields
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (w_accept) begin
            r_mode    <= i_mode;
            r_addr    <= i_node_addr;
            r_seq     <= i_seq_num;
            r_now     <= i_now_time;
            r_rd_idx  <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
            r_hit_seq <= '0;
            r_free_ok <= 1'b0;
            r_free_idx <= '0;
            r_cnt     <= '0;
        end else begin
            if (r_state == ST_SCAN) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_cmp_vld) begin
                case (r_mode)
                    nst_pkg::MODE_HELLO, nst_pkg::MODE_LOOKUP: begin
                        if (w_cmp_v && !r_hit && (w_rdata.addr == r_addr)) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_cmp_idx;
                            r_hit_seq <= w_rdata.seq;
                        end
                        if (!w_cmp_v && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_cmp_idx;
                        end
                    end
                    nst_pkg::MODE_SWEEP: begin
                        if (w_cmp_v && (w_rdata.expiry < r_now)) begin
                            r_cnt <= w_cnt_inc;
                        end
                    end
                    nst_pkg::MODE_CLEAR: begin
                        if (w_cmp_v) begin
                            r_cnt <= w_cnt_inc;
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (r_state == ST_UPD) begin
            case (r_mode)
                nst_pkg::MODE_HELLO: begin
                    r_res_found <= r_hit;
                    r_res_eseq  <= r_hit ? ((r_seq >= r_hit_seq) ? r_seq : r_hit_seq)
                                         : (r_free_ok ? r_seq : '0);
                    r_res_ins   <= !r_hit && r_free_ok;
                    r_res_full  <= !r_hit && !r_free_ok;
                end
                nst_pkg::MODE_LOOKUP: begin
                    r_res_found <= r_hit;
                    r_res_eseq  <= r_hit ? r_hit_seq : '0;
                    r_res_ins   <= 1'b0;
                    r_res_full  <= 1'b0;
                end
                default: begin
                    r_res_found <= 1'b0;
                    r_res_eseq  <= '0;
                    r_res_ins   <= 1'b0;
                    r_res_full  <= 1'b0;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && w_out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            o_found           <= r_res_found;
            o_entry_seq       <= r_res_eseq;
            o_inserted        <= r_res_ins;
            o_table_full      <= r_res_full;
            o_removed_count   <= r_cnt;
            o_set_seq         <= r_set_seq;
            o_changes_pending <= r_chg;
        end
    end

endmodule

/* rtl/core/nst_checker.sv */
// port-level checks for the neighbor selector table
module nst_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_found,
    input logic [nst_pkg::SEQ_W-1:0]   o_entry_seq,
    input logic                        o_inserted,
    input logic                        o_table_full,
    input logic [nst_pkg::CNT_W-1:0]   o_removed_count,
    input logic [nst_pkg::SEQ_W-1:0]   o_set_seq,
    input logic                        o_changes_pending
);

    // one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

    a_insert_raises_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_inserted) |-> (o_changes_pending && !o_found && !o_table_full))
        else $error("insert result inconsistent");

    a_full_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (!o_found && (o_entry_seq == '0)
            && (o_removed_count == '0)))
        else $error("dropped insert reports an entry");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_entry_seq)
            && $stable(o_set_seq) && $stable(o_found)))
        else $error("stalled result changed");

endmodule

bind neighbor_selector_table_core nst_checker u_nst_checker (.*);
